@@ rtl/core/sixteen_bit_alu_with_ex_register_core_macros.svh @@
// Assertion helpers for the ALU core
`ifndef SIXTEEN_BIT_ALU_WITH_EX_REGISTER_CORE_MACROS_SVH
`define SIXTEEN_BIT_ALU_WITH_EX_REGISTER_CORE_MACROS_SVH
// implication checked every clock, quiet in reset
`define SBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Types, opcodes and control structs shared by the ALU core.
// ----------------------------------------------------------------------------
package sba_pkg;
  typedef struct packed {
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [15:0] result_b;
    logic        write_b;
    logic        skip_next;
    logic [1:0]  index_step;
    logic [15:0] ex_value;
    logic        bad_opcode;
  } out_t;

  localparam logic [4:0] OP_SET = 5'h01;
  localparam logic [4:0] OP_ADD = 5'h02;
  localparam logic [4:0] OP_SUB = 5'h03;
  localparam logic [4:0] OP_MUL = 5'h04;
  localparam logic [4:0] OP_MLI = 5'h05;
  localparam logic [4:0] OP_DIV = 5'h06;
  localparam logic [4:0] OP_DVI = 5'h07;
  localparam logic [4:0] OP_MOD = 5'h08;
  localparam logic [4:0] OP_MDI = 5'h09;
  localparam logic [4:0] OP_AND = 5'h0a;
  localparam logic [4:0] OP_BOR = 5'h0b;
  localparam logic [4:0] OP_XOR = 5'h0c;
  localparam logic [4:0] OP_SHR = 5'h0d;
  localparam logic [4:0] OP_ASR = 5'h0e;
  localparam logic [4:0] OP_SHL = 5'h0f;
  localparam logic [4:0] OP_IFB = 5'h10;
  localparam logic [4:0] OP_IFC = 5'h11;
  localparam logic [4:0] OP_IFE = 5'h12;
  localparam logic [4:0] OP_IFN = 5'h13;
  localparam logic [4:0] OP_IFG = 5'h14;
  localparam logic [4:0] OP_IFA = 5'h15;
  localparam logic [4:0] OP_IFL = 5'h16;
  localparam logic [4:0] OP_IFU = 5'h17;
  localparam logic [4:0] OP_ADX = 5'h1a;
  localparam logic [4:0] OP_SBX = 5'h1b;
  localparam logic [4:0] OP_STI = 5'h1e;
  localparam logic [4:0] OP_STD = 5'h1f;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  localparam int DIV_STEPS = 32;
  localparam logic [15:0] MASK16 = 16'hffff;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic div_step;  // one restoring division step
    logic finish;    // form the result and update EX
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;  // loaded opcode uses the divider
  } sts_t;
endpackage

@@ rtl/core/sba_ctrl.sv @@
// ----------------------------------------------------------------------------
// sba_ctrl
// Sequencer: load, iterate the divider when needed, finish, present.
// ----------------------------------------------------------------------------
module sba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sba_pkg::sts_t sts,
  output sba_pkg::cmd_t cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       oval_r, oval_nxt;
  logic       accept;

  // take a new beat when idle and the output slot is free or draining
  assign in_stall  = !(state_r == ST_IDLE && (!oval_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        if (sts.need_div) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'(sba_pkg::DIV_STEPS - 1)) state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        oval_nxt   = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end
endmodule

@@ rtl/core/sba_dp.sv @@
// ----------------------------------------------------------------------------
// sba_dp
// Operand registers, serial divider, result formation and EX register.
// ----------------------------------------------------------------------------
module sba_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  sba_pkg::in_t  in_data,
  input  sba_pkg::cmd_t cmd,
  output sba_pkg::sts_t sts,
  output sba_pkg::out_t out_data
);
  logic [4:0]  op_r;
  logic [15:0] a_r, b_r, ex_r, ex_nxt;
  logic        neg_q_r, neg_r_r;
  // 32-bit dividend shifted through quotient register, 16-bit divisor
  logic [31:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] dvs_r;
  logic [16:0] trial;
  sba_pkg::out_t res_r, res_nxt;

  logic        is_signed_div, is_mod;
  logic [15:0] abs_a, abs_b;
  logic [31:0] prod_u, prod_s;
  logic [31:0] quot;
  logic [15:0] remv;
  logic [31:0] shl_t, shr_t, asr_t;
  logic        big_sh;
  logic [16:0] add_t;
  logic [17:0] adx_t;
  logic signed [17:0] sbx_t;
  logic [15:0] nb, ex;
  logic        wr, skip, bad;
  logic [1:0]  step;

  assign is_mod = (in_data.req_type == sba_pkg::OP_MOD) || (in_data.req_type == sba_pkg::OP_MDI);
  assign is_signed_div = (in_data.req_type == sba_pkg::OP_DVI)
                      || (in_data.req_type == sba_pkg::OP_MDI);
  assign abs_a = (is_signed_div && in_data.operand_a[15]) ? 16'(-in_data.operand_a)
                                                         : in_data.operand_a;
  assign abs_b = (is_signed_div && in_data.operand_b[15]) ? 16'(-in_data.operand_b)
                                                         : in_data.operand_b;

  assign sts.need_div = (op_r == sba_pkg::OP_DIV) || (op_r == sba_pkg::OP_DVI)
                     || (op_r == sba_pkg::OP_MOD) || (op_r == sba_pkg::OP_MDI);
  assign trial = {rem_r[15:0], q_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.req_type;
      a_r     <= in_data.operand_a;
      b_r     <= in_data.operand_b;
      dvs_r   <= abs_a;
      // mod divides B itself so the remainder is B mod A; div divides B * 2^16
      q_r     <= is_mod ? {16'h0000, abs_b} : {abs_b, 16'h0000};
      rem_r   <= '0;
      neg_q_r <= is_signed_div && (in_data.operand_a[15] ^ in_data.operand_b[15]);
      neg_r_r <= is_signed_div && in_data.operand_b[15];
    end else if (cmd.div_step) begin
      // restoring step: shift one dividend bit in, subtract when it fits
      if (!trial[16]) begin
        rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  // low half of the signed quotient is the fraction that goes to EX
  assign quot = neg_q_r ? 32'(-q_r) : q_r;
  // remainder takes the sign of the dividend
  assign remv = neg_r_r ? 16'(-rem_r[15:0]) : rem_r[15:0];

  assign prod_u = {16'h0000, a_r} * {16'h0000, b_r};
  assign prod_s = 32'($signed({{16{a_r[15]}}, a_r}) * $signed({{16{b_r[15]}}, b_r}));
  assign big_sh = (a_r[15:5] != '0);
  assign shl_t  = big_sh ? 32'h0 : ({16'h0000, b_r} << a_r[4:0]);
  assign shr_t  = big_sh ? 32'h0 : ({b_r, 16'h0000} >> a_r[4:0]);
  assign asr_t  = big_sh ? {32{b_r[15]}} : 32'($signed({b_r, 16'h0000}) >>> a_r[4:0]);
  assign add_t  = {1'b0, a_r} + {1'b0, b_r};
  assign adx_t  = {2'b00, b_r} + {2'b00, a_r} + {2'b00, ex_r};
  assign sbx_t  = $signed({2'b00, b_r}) - $signed({2'b00, a_r}) + $signed({2'b00, ex_r});

  always_comb begin
    nb = b_r; ex = ex_r; wr = 1'b1; skip = 1'b0; step = sba_pkg::STEP_NONE; bad = 1'b0;
    unique case (op_r)
      sba_pkg::OP_SET: nb = a_r;
      sba_pkg::OP_ADD: begin nb = add_t[15:0]; ex = {15'd0, add_t[16]}; end
      sba_pkg::OP_SUB: begin
        nb = b_r - a_r; ex = (b_r < a_r) ? sba_pkg::MASK16 : 16'h0000;
      end
      sba_pkg::OP_MUL: begin nb = prod_u[15:0]; ex = prod_u[31:16]; end
      sba_pkg::OP_MLI: begin nb = prod_s[15:0]; ex = prod_s[31:16]; end
      sba_pkg::OP_DIV, sba_pkg::OP_DVI: begin
        if (a_r == 16'h0000) begin nb = '0; ex = '0; end
        else begin
          nb = neg_q_r ? 16'(-q_r[31:16]) : q_r[31:16];
          ex = quot[15:0];
        end
      end
      sba_pkg::OP_MOD, sba_pkg::OP_MDI: nb = (a_r == 16'h0000) ? 16'h0000 : remv;
      sba_pkg::OP_AND: nb = a_r & b_r;
      sba_pkg::OP_BOR: nb = a_r | b_r;
      sba_pkg::OP_XOR: nb = a_r ^ b_r;
      sba_pkg::OP_SHR: begin nb = shr_t[31:16]; ex = shr_t[15:0]; end
      sba_pkg::OP_ASR: begin nb = asr_t[31:16]; ex = asr_t[15:0]; end
      sba_pkg::OP_SHL: begin nb = shl_t[15:0]; ex = shl_t[31:16]; end
      sba_pkg::OP_IFB: begin wr = 1'b0; skip = (b_r & a_r) == '0; end
      sba_pkg::OP_IFC: begin wr = 1'b0; skip = (b_r & a_r) != '0; end
      sba_pkg::OP_IFE: begin wr = 1'b0; skip = b_r != a_r; end
      sba_pkg::OP_IFN: begin wr = 1'b0; skip = b_r == a_r; end
      sba_pkg::OP_IFG: begin wr = 1'b0; skip = b_r <= a_r; end
      sba_pkg::OP_IFA: begin wr = 1'b0; skip = $signed(b_r) <= $signed(a_r); end
      sba_pkg::OP_IFL: begin wr = 1'b0; skip = b_r >= a_r; end
      sba_pkg::OP_IFU: begin wr = 1'b0; skip = $signed(b_r) >= $signed(a_r); end
      sba_pkg::OP_ADX: begin nb = adx_t[15:0]; ex = {15'd0, adx_t[17:16] != 2'b00}; end
      sba_pkg::OP_SBX: begin
        nb = sbx_t[15:0];
        ex = sbx_t[17] ? sba_pkg::MASK16 : ((sbx_t[16]) ? 16'h0001 : 16'h0000);
      end
      sba_pkg::OP_STI: begin nb = a_r; step = sba_pkg::STEP_INC; end
      sba_pkg::OP_STD: begin nb = a_r; step = sba_pkg::STEP_DEC; end
      default: begin wr = 1'b0; bad = 1'b1; end
    endcase
    ex_nxt = ex;
    res_nxt.result_b   = wr ? nb : b_r;
    res_nxt.write_b    = wr;
    res_nxt.skip_next  = skip;
    res_nxt.index_step = step;
    res_nxt.ex_value   = ex;
    res_nxt.bad_opcode = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ex_r <= '0;
    else if (cmd.finish) ex_r <= ex_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end
  assign out_data = res_r;
endmodule

@@ rtl/core/sixteen_bit_alu_with_ex_register_core.sv @@
// ----------------------------------------------------------------------------
// sixteen_bit_alu_with_ex_register_core
// Basic-opcode ALU of a 16-bit CPU with its EX register.
// ----------------------------------------------------------------------------
// One instruction at a time. After the accepting edge each beat passes the
// DIV and FIN states before its result is presented; div, dvi, mod and mdi
// stay in DIV for a 32-step restoring divider that retires one quotient bit
// per cycle. The result waits in an output register, and the next beat is
// taken in the cycle the result drains, so no new beat is taken while one is
// still in DIV or FIN.
module sixteen_bit_alu_with_ex_register_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sba_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sba_pkg::out_t out_data
);
  `include "sixteen_bit_alu_with_ex_register_core_macros.svh"

  sba_pkg::cmd_t cmd;
  sba_pkg::sts_t sts;

  sba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  sba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );

  `SBA_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
  `SBA_ASSERT_NXT(a_fin_valid, cmd.finish, out_valid, "finished beat not presented")
  `SBA_ASSERT_IMP(a_no_take_busy, cmd.div_step || cmd.finish, in_stall,
                  "input taken while busy")
endmodule
